/* rtl/text_to_stroke_layout_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for text_to_stroke_layout
// Concurrent checks on clk with rst_n; they compile to nothing under SYNTH.
// ----------------------------------------------------------------------------
`ifndef TEXT_TO_STROKE_LAYOUT_DEFINES_SVH
`define TEXT_TO_STROKE_LAYOUT_DEFINES_SVH
`ifndef SYNTH
// Condition must hold in the same cycle as the trigger.
`define TTSL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("text_to_stroke_layout: assertion failed");
// Condition must hold in the cycle after the trigger.
`define TTSL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text_to_stroke_layout: assertion failed");
`else
`define TTSL_ASSERT_IMP(label, ante, cons)
`define TTSL_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* rtl/ttsl_pkg.sv */
// ----------------------------------------------------------------------------
// ttsl_pkg
// Types, codes and layout constants shared by the text-to-stroke block.
// ----------------------------------------------------------------------------
package ttsl_pkg;

  typedef logic signed [15:0] row_col_t;
  typedef logic signed [31:0] coord_t;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEXT = 1'b1;

  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_SPACE   = 8'd32;

  localparam logic [15:0] HEADER_MARK  = 16'd999;
  localparam logic [33:0] MAX_WIDTH_MM = 34'd100;
  localparam int unsigned COL_STEP     = 18;
  localparam int unsigned LINE_STEP    = 36;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int ADV_W      = 7;
  localparam int ROWS_CFG_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_ADVANCE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FONT_ROW_COUNT = 1'd1;

  localparam logic [ADV_W-1:0] ADV_RESET = 7'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WCHK,
    S_SCAN,
    S_EMIT_RD,
    S_EMIT_X,
    S_EMIT_Y,
    S_ADV
  } state_t;

endpackage

/* rtl/ttsl_in_if.sv */
// ----------------------------------------------------------------------------
// ttsl_in_if
// Input channel: font row loads and text characters, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ttsl_in_if;
  import ttsl_pkg::*;

  logic       valid;
  logic       ready;
  logic       cmd;
  logic [9:0] row_index;
  row_col_t   row_x;
  row_col_t   row_y;
  row_col_t   row_third;
  logic [7:0] char_code;
  logic [7:0] word_chars;

  modport source (output valid, cmd, row_index, row_x, row_y, row_third, char_code,
                  word_chars, input ready);
  modport sink (input valid, cmd, row_index, row_x, row_y, row_third, char_code,
                word_chars, output ready);
endinterface

/* rtl/ttsl_out_if.sv */
// ----------------------------------------------------------------------------
// ttsl_out_if
// Output channel: one placed pen stroke per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ttsl_out_if;
  import ttsl_pkg::*;

  logic        valid;
  logic        ready;
  coord_t      stroke_x;
  coord_t      stroke_y;
  row_col_t    stroke_pen;
  logic [31:0] stroke_number;
  logic        last_stroke;

  modport source (output valid, stroke_x, stroke_y, stroke_pen, stroke_number,
                  last_stroke, input ready);
  modport sink (input valid, stroke_x, stroke_y, stroke_pen, stroke_number,
                last_stroke, output ready);
endinterface

/* rtl/text_to_stroke_layout.sv */
// ----------------------------------------------------------------------------
// text_to_stroke_layout
// Lays out text as pen strokes from a stroke-font table held in block RAM.
// ----------------------------------------------------------------------------
// Load items and newlines are taken in S_IDLE; spaces also pass through S_ADV.
// A glyph passes through S_WCHK at a word start, then the header scan over the
// font RAM's single read port at one row per cycle, then S_EMIT_RD, S_EMIT_X
// and S_EMIT_Y for each stroke through the shared adder (S_EMIT_Y waits while
// the output holds an untaken stroke), then S_ADV if a header was found.
// Reset restores state, counters and control registers; payload registers are
// not reset, and the font table holds no defined contents until rows are loaded.
module text_to_stroke_layout #(
  parameter int FONT_ROWS     = 1024,
  parameter int GLYPH_STROKES = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  ttsl_in_if.sink                             in_item,
  ttsl_out_if.source                          out_item,
  input  logic                                cfg_we,
  input  logic [ttsl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ttsl_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ttsl_pkg::*;

  `include "text_to_stroke_layout_defines.svh"

  localparam int AW   = $clog2(FONT_ROWS);
  localparam int CW   = AW + 1;
  localparam int LW   = (CW > ROWS_CFG_W) ? CW : ROWS_CFG_W;
  localparam int IDXW = (CW > 10) ? CW : 10;
  localparam int MW   = (CW > 16) ? CW : 16;
  localparam int NW   = $clog2(GLYPH_STROKES + 1);

  localparam logic [CW-1:0] LAST_ROW = CW'(FONT_ROWS - 1);

  // Control and configuration state.
  state_t              state_r, state_nxt;
  logic [ADV_W-1:0]    adv_r;
  logic [ROWS_CFG_W-1:0] rows_r;
  logic [15:0]         col_r, col_nxt;
  logic [15:0]         line_r, line_nxt;
  logic [31:0]         width_r, width_nxt;
  logic [31:0]         scnt_r, scnt_nxt;
  logic                inside_r, inside_nxt;
  logic [CW-1:0]       scan_addr_r, scan_addr_nxt;
  logic                pend_r, pend_nxt;
  logic [AW-1:0]       pend_addr_r, pend_addr_nxt;
  logic [AW-1:0]       start_r, start_nxt;
  logic [NW-1:0]       n_r, n_nxt;
  logic [NW-1:0]       k_r, k_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [7:0]          code_r, code_nxt;
  logic [7:0]          word_r, word_nxt;
  logic [31:0]         x_r, x_nxt;
  logic [31:0]         out_x_r, out_x_nxt;
  logic [31:0]         out_y_r, out_y_nxt;
  logic [15:0]         out_pen_r, out_pen_nxt;
  logic [31:0]         out_num_r, out_num_nxt;
  logic                out_last_r, out_last_nxt;

  // Font RAM.
  logic [47:0]         font_mem [FONT_ROWS];
  logic [47:0]         rd_q;
  logic                rd_en, mem_we;
  logic [AW-1:0]       rd_addr;

  logic [15:0]         rd_x, rd_y, rd_t;
  logic                in_acc, row_in_range, hdr_hit, scan_more, out_free;
  logic [LW-1:0]       limit;
  logic [AW-1:0]       emit_addr;
  logic [14:0]         prod;
  logic [20:0]         col_off;
  logic [21:0]         line_off;
  logic [MW-1:0]       cnt_c, gs_c, room_c, n1_c, n2_c;

  // Shared adder.
  logic [33:0]         alu_a, alu_b, alu_sum;
  logic                alu_cin;

  assign rd_x = rd_q[47:32];
  assign rd_y = rd_q[31:16];
  assign rd_t = rd_q[15:0];

  assign in_acc       = in_item.valid && in_item.ready;
  assign in_item.ready = (state_r == S_IDLE);
  assign row_in_range = IDXW'(in_item.row_index) < IDXW'(FONT_ROWS);
  assign limit        = (LW'(rows_r) > LW'(FONT_ROWS)) ? LW'(FONT_ROWS) : LW'(rows_r);
  assign scan_more    = LW'(scan_addr_r) < limit;
  assign hdr_hit      = (rd_x == HEADER_MARK) && (rd_y == {8'd0, code_r});
  assign emit_addr    = start_r + AW'(k_r);
  assign out_free     = !out_valid_r || out_item.ready;

  assign prod     = 15'(word_r) * 15'(adv_r);
  assign col_off  = 21'(col_r) * 21'(COL_STEP);
  assign line_off = 22'(line_r) * 22'(LINE_STEP);

  // Stroke count from a header, negative counts as zero, clipped to the glyph limit and table end.
  assign cnt_c  = rd_t[15] ? '0 : MW'(rd_t[14:0]);
  assign gs_c   = MW'(GLYPH_STROKES);
  assign room_c = MW'(LAST_ROW - CW'(pend_addr_r));
  assign n1_c   = (cnt_c < gs_c) ? cnt_c : gs_c;
  assign n2_c   = (n1_c < room_c) ? n1_c : room_c;

  always_comb begin
    alu_a   = {2'b00, width_r};
    alu_b   = {27'd0, adv_r};
    alu_cin = 1'b0;
    unique case (state_r)
      S_WCHK: begin
        alu_b = {19'd0, prod};
      end
      S_EMIT_X: begin
        alu_a = {{18{rd_x[15]}}, rd_x};
        alu_b = {13'd0, col_off};
      end
      S_EMIT_Y: begin
        // Subtract the line offset as a plus inverted operand with carry in.
        alu_a   = {{18{rd_y[15]}}, rd_y};
        alu_b   = ~{12'd0, line_off};
        alu_cin = 1'b1;
      end
      default: begin
        alu_a = {2'b00, width_r};
      end
    endcase
  end

  assign alu_sum = alu_a + alu_b + 34'(alu_cin);

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    line_nxt      = line_r;
    width_nxt     = width_r;
    scnt_nxt      = scnt_r;
    inside_nxt    = inside_r;
    scan_addr_nxt = scan_addr_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    start_nxt     = start_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    code_nxt      = code_r;
    word_nxt      = word_r;
    x_nxt         = x_r;
    out_valid_nxt = out_valid_r && !out_item.ready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_pen_nxt   = out_pen_r;
    out_num_nxt   = out_num_r;
    out_last_nxt  = out_last_r;
    rd_en         = 1'b0;
    rd_addr       = scan_addr_r[AW-1:0];
    mem_we        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_item.cmd == CMD_LOAD) begin
            mem_we = row_in_range;
          end else begin
            code_nxt = in_item.char_code;
            word_nxt = in_item.word_chars;
            priority if (in_item.char_code == CODE_NEWLINE) begin
              line_nxt   = line_r + 16'd1;
              col_nxt    = '0;
              width_nxt  = '0;
              inside_nxt = 1'b0;
            end else if (in_item.char_code == CODE_SPACE) begin
              inside_nxt = 1'b0;
              state_nxt  = S_ADV;
            end else begin
              scan_addr_nxt = '0;
              pend_nxt      = 1'b0;
              state_nxt     = inside_r ? S_SCAN : S_WCHK;
            end
          end
        end
      end
      S_WCHK: begin
        // Word start: wrap when the whole word would not fit on this line.
        inside_nxt = 1'b1;
        if (alu_sum > MAX_WIDTH_MM) begin
          line_nxt  = line_r + 16'd1;
          col_nxt   = '0;
          width_nxt = '0;
        end
        scan_addr_nxt = '0;
        pend_nxt      = 1'b0;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        // Reads are issued one row per cycle; each row is checked in the next cycle.
        if (pend_r && hdr_hit) begin
          start_nxt = pend_addr_r;
          n_nxt     = n2_c[NW-1:0];
          k_nxt     = NW'(1);
          pend_nxt  = 1'b0;
          state_nxt = (n2_c == '0) ? S_ADV : S_EMIT_RD;
        end else if (!pend_r && !scan_more) begin
          state_nxt = S_IDLE;
        end else begin
          rd_en         = scan_more;
          pend_nxt      = scan_more;
          pend_addr_nxt = scan_addr_r[AW-1:0];
          if (scan_more) begin
            scan_addr_nxt = scan_addr_r + CW'(1);
          end
        end
      end
      S_EMIT_RD: begin
        rd_en     = 1'b1;
        rd_addr   = emit_addr;
        state_nxt = S_EMIT_X;
      end
      S_EMIT_X: begin
        x_nxt     = alu_sum[31:0];
        state_nxt = S_EMIT_Y;
      end
      S_EMIT_Y: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = x_r;
          out_y_nxt     = alu_sum[31:0];
          out_pen_nxt   = rd_t;
          out_num_nxt   = scnt_r;
          out_last_nxt  = (k_r == n_r);
          scnt_nxt      = scnt_r + 32'd1;
          if (k_r == n_r) begin
            state_nxt = S_ADV;
          end else begin
            k_nxt     = k_r + NW'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end
      S_ADV: begin
        col_nxt   = col_r + 16'd1;
        width_nxt = alu_sum[32] ? '1 : alu_sum[31:0];
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adv_r       <= ADV_RESET;
      rows_r      <= '0;
      col_r       <= '0;
      line_r      <= '0;
      width_r     <= '0;
      scnt_r      <= '0;
      inside_r    <= 1'b0;
      scan_addr_r <= '0;
      pend_r      <= 1'b0;
      pend_addr_r <= '0;
      start_r     <= '0;
      n_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_CHAR_ADVANCE) begin
        adv_r <= cfg_data[ADV_W-1:0];
      end
      if (cfg_we && cfg_index == CFG_FONT_ROW_COUNT) begin
        rows_r <= cfg_data[ROWS_CFG_W-1:0];
      end
      col_r       <= col_nxt;
      line_r      <= line_nxt;
      width_r     <= width_nxt;
      scnt_r      <= scnt_nxt;
      inside_r    <= inside_nxt;
      scan_addr_r <= scan_addr_nxt;
      pend_r      <= pend_nxt;
      pend_addr_r <= pend_addr_nxt;
      start_r     <= start_nxt;
      n_r         <= n_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r     <= code_nxt;
    word_r     <= word_nxt;
    x_r        <= x_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_pen_r  <= out_pen_nxt;
    out_num_r  <= out_num_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      font_mem[AW'(in_item.row_index)] <= {in_item.row_x, in_item.row_y, in_item.row_third};
    end
    if (rd_en) begin
      rd_q <= font_mem[rd_addr];
    end
  end

  assign out_item.valid         = out_valid_r;
  assign out_item.stroke_x      = $signed(out_x_r);
  assign out_item.stroke_y      = $signed(out_y_r);
  assign out_item.stroke_pen    = $signed(out_pen_r);
  assign out_item.stroke_number = out_num_r;
  assign out_item.last_stroke   = out_last_r;

  `TTSL_ASSERT_IMP(a_emit_k_range, (state_r == S_EMIT_RD || state_r == S_EMIT_X || state_r == S_EMIT_Y), (k_r != '0) && (k_r <= n_r))
  `TTSL_ASSERT_IMP(a_scan_in_limit, state_r == S_SCAN, LW'(scan_addr_r) <= limit)
  `TTSL_ASSERT_IMP(a_emit_addr_in_table, state_r == S_EMIT_RD, (CW'(start_r) + CW'(k_r)) <= LAST_ROW)
  `TTSL_ASSERT_NXT(a_text_busy, in_acc && in_item.cmd == CMD_TEXT && in_item.char_code != CODE_NEWLINE, state_r != S_IDLE)

endmodule

/* sim/text_to_stroke_layout_checker.sv */
// ----------------------------------------------------------------------------
// text_to_stroke_layout_checker
// Watches the item and stroke channels and the register port, keeps its own
// copy of the font table and layout state, and checks every stroke in order.
// ----------------------------------------------------------------------------
module text_to_stroke_layout_checker
  import ttsl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  ttsl_in_if                    in_mon,
  ttsl_out_if                   out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  run_done,
  output int                    mismatch_total,
  output int                    strokes_pending,
  output int                    strokes_checked
);

  localparam int TABLE_ROWS  = 1024;
  localparam int MAX_STROKES = 64;

  typedef struct packed {
    coord_t      x;
    coord_t      y;
    row_col_t    pen;
    logic [31:0] number;
    logic        last;
  } stroke_t;

  row_col_t font_x   [TABLE_ROWS];
  row_col_t font_y   [TABLE_ROWS];
  row_col_t font_pen [TABLE_ROWS];

  logic [ADV_W-1:0]      advance_mm;
  logic [ROWS_CFG_W-1:0] rows_to_scan;
  logic [15:0]           column_pos;
  logic [15:0]           line_pos;
  logic [31:0]           width_mm;
  logic [31:0]           next_stroke;
  logic                  in_word;

  stroke_t expected_strokes[$];
  int      errors = 0;
  int      checked = 0;
  logic    leftovers_done = 1'b0;

  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  task automatic next_line();
    line_pos   = line_pos + 16'd1;
    column_pos = '0;
    width_mm   = '0;
  endtask

  // Line width saturates instead of wrapping.
  task automatic widen();
    logic [32:0] sum;
    sum      = {1'b0, width_mm} + 33'(advance_mm);
    width_mm = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endtask

  task automatic lay_out_char(input logic [7:0] code, input logic [7:0] word_len);
    int          limit;
    int          row;
    int          first_row;
    int          header_count;
    int          n_strokes;
    int          k;
    logic        found;
    logic [63:0] need;
    stroke_t     s;
    if (code == CODE_NEWLINE) begin
      next_line();
      in_word = 1'b0;
      return;
    end
    if (code == CODE_SPACE) begin
      column_pos = column_pos + 16'd1;
      widen();
      in_word = 1'b0;
      return;
    end
    // Word wrap is decided once, on the first character of a word.
    if (!in_word) begin
      need    = 64'(width_mm) + 64'(word_len) * 64'(advance_mm);
      in_word = 1'b1;
      if (need > 64'(MAX_WIDTH_MM)) next_line();
    end
    limit     = (int'(rows_to_scan) > TABLE_ROWS) ? TABLE_ROWS : int'(rows_to_scan);
    found     = 1'b0;
    first_row = 0;
    for (row = 0; row < limit && !found; row++) begin
      if (font_x[row] == HEADER_MARK && font_y[row] == {8'h00, code}) begin
        found     = 1'b1;
        first_row = row;
      end
    end
    if (!found) return;
    header_count = int'(font_pen[first_row]);
    n_strokes    = (header_count > 0) ? header_count : 0;
    if (n_strokes > MAX_STROKES) n_strokes = MAX_STROKES;
    if (n_strokes > TABLE_ROWS - 1 - first_row) n_strokes = TABLE_ROWS - 1 - first_row;
    for (k = 1; k <= n_strokes; k++) begin
      row      = first_row + k;
      s.x      = int'(font_x[row]) + int'(COL_STEP) * int'(column_pos);
      s.y      = int'(font_y[row]) - int'(LINE_STEP) * int'(line_pos);
      s.pen    = font_pen[row];
      s.number = next_stroke;
      s.last   = (k == n_strokes);
      expected_strokes.push_back(s);
      next_stroke = next_stroke + 32'd1;
    end
    column_pos = column_pos + 16'd1;
    widen();
  endtask

  task automatic check_stroke();
    stroke_t want;
    if (expected_strokes.size() == 0) begin
      flag_mismatch($sformatf("stroke number %0d arrived with nothing expected",
                              out_mon.stroke_number));
      return;
    end
    want = expected_strokes.pop_front();
    if (out_mon.stroke_x !== want.x)
      flag_mismatch($sformatf("stroke %0d x: got %0d, expected %0d", want.number,
                              out_mon.stroke_x, $signed(want.x)));
    if (out_mon.stroke_y !== want.y)
      flag_mismatch($sformatf("stroke %0d y: got %0d, expected %0d", want.number,
                              out_mon.stroke_y, $signed(want.y)));
    if (out_mon.stroke_pen !== want.pen)
      flag_mismatch($sformatf("stroke %0d pen: got %0d, expected %0d", want.number,
                              out_mon.stroke_pen, $signed(want.pen)));
    if (out_mon.stroke_number !== want.number)
      flag_mismatch($sformatf("stroke %0d number: got %0d", want.number,
                              out_mon.stroke_number));
    if (out_mon.last_stroke !== want.last)
      flag_mismatch($sformatf("stroke %0d last flag: got %b, expected %b", want.number,
                              out_mon.last_stroke, want.last));
    checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      advance_mm   = ADV_RESET;
      rows_to_scan = '0;
      column_pos   = '0;
      line_pos     = '0;
      width_mm     = '0;
      next_stroke  = '0;
      in_word      = 1'b0;
      expected_strokes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHAR_ADVANCE:   advance_mm = cfg_data[ADV_W-1:0];
          CFG_FONT_ROW_COUNT: rows_to_scan = cfg_data[ROWS_CFG_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) check_stroke();
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.cmd == CMD_LOAD) begin
          font_x[in_mon.row_index]   = in_mon.row_x;
          font_y[in_mon.row_index]   = in_mon.row_y;
          font_pen[in_mon.row_index] = in_mon.row_third;
        end else begin
          lay_out_char(in_mon.char_code, in_mon.word_chars);
        end
      end
      if (run_done && !leftovers_done) begin
        leftovers_done = 1'b1;
        if (expected_strokes.size() != 0)
          flag_mismatch($sformatf("%0d expected strokes never arrived, first is number %0d",
                                  expected_strokes.size(), expected_strokes[0].number));
      end
    end
    // Handed out through nonblocking updates so the stimulus reads settled values.
    mismatch_total  <= errors;
    strokes_pending <= expected_strokes.size();
    strokes_checked <= checked;
  end

endmodule

/* sim/text_to_stroke_layout_tb.sv */
// ----------------------------------------------------------------------------
// text_to_stroke_layout_tb
// Loads a stroke font with ordinary, shadowed, truncated and empty glyphs,
// then types directed and random text under several register settings while
// both channel ends mostly idle and stall at random; the checker grades each stroke.
// ----------------------------------------------------------------------------
module text_to_stroke_layout_tb;
  import ttsl_pkg::*;

  localparam int TABLE_ROWS       = 1024;
  localparam int SETTLE_CYCLES    = 1300;
  localparam int LONG_HOLD_CYCLES = 900;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  run_done;
  logic                  idle_bursts = 1'b1;
  logic                  hold_request = 1'b0;

  int mismatch_total;
  int strokes_pending;
  int strokes_checked;
  int text_items = 0;
  int load_items = 0;
  int settings_used = 0;

  row_col_t   image_x   [TABLE_ROWS];
  row_col_t   image_y   [TABLE_ROWS];
  row_col_t   image_pen [TABLE_ROWS];
  logic [7:0] alphabet [17];
  int         glyph_heads [8];

  ttsl_in_if  in_ch ();
  ttsl_out_if out_ch ();

  text_to_stroke_layout u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_ch),
    .out_item  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  text_to_stroke_layout_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .run_done        (run_done),
    .mismatch_total  (mismatch_total),
    .strokes_pending (strokes_pending),
    .strokes_checked (strokes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d strokes still expected", strokes_pending);
    $display("== FAIL ==");
    $finish;
  end

  // Stroke receiver: random stalls, plus one long hold on request.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_request <= 1'b0;
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else if (idle_bursts && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic place_glyph(input int head, input logic [7:0] code, input int count);
    int rows;
    int k;
    rows = (count < 0) ? 0 : count;
    if (rows > 64) rows = 64;
    if (rows > TABLE_ROWS - 1 - head) rows = TABLE_ROWS - 1 - head;
    image_x[head]   = HEADER_MARK;
    image_y[head]   = {8'h00, code};
    image_pen[head] = 16'(count);
    for (k = 1; k <= rows; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        image_x[head + k] = 16'($urandom);
        image_y[head + k] = 16'($urandom);
      end else begin
        image_x[head + k] = 16'($urandom_range(0, 20));
        image_y[head + k] = 16'($urandom_range(0, 20));
      end
      image_pen[head + k] = 16'($urandom_range(0, 1));
    end
  endtask

  // Valid stays high from one item to the next unless a gap is taken.
  task automatic offer(input logic cmd, input logic [9:0] idx, input row_col_t rx,
                       input row_col_t ry, input row_col_t rt, input logic [7:0] code,
                       input logic [7:0] wlen);
    if (idle_bursts && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.row_index  <= idx;
    in_ch.row_x      <= rx;
    in_ch.row_y      <= ry;
    in_ch.row_third  <= rt;
    in_ch.char_code  <= code;
    in_ch.word_chars <= wlen;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (cmd == CMD_TEXT) text_items++;
    else load_items++;
  endtask

  task automatic load_row(input logic [9:0] idx, input row_col_t rx, input row_col_t ry,
                          input row_col_t rt);
    offer(CMD_LOAD, idx, rx, ry, rt, 8'($urandom), 8'($urandom));
  endtask

  task automatic type_char(input logic [7:0] code, input logic [7:0] wlen);
    offer(CMD_TEXT, 10'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), code, wlen);
  endtask

  // A character with no glyph produces nothing, so allow a full scan to finish.
  task automatic wait_for_strokes();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (strokes_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input int advance, input int rows);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CHAR_ADVANCE;
    cfg_data  <= CFG_DATA_W'(advance);
    @(posedge clk);
    cfg_index <= CFG_FONT_ROW_COUNT;
    cfg_data  <= CFG_DATA_W'(rows);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic random_text(input int n);
    int         start_count;
    int         len;
    int         pick;
    int         i;
    logic [7:0] code;
    start_count = text_items + load_items;
    while (text_items + load_items - start_count < n) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        type_char(8'($urandom), 8'($urandom));
      end else if (pick == 1) begin
        if ($urandom_range(0, 1) == 1)
          load_row(10'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        else
          load_row(10'(glyph_heads[$urandom_range(0, 7)] + $urandom_range(1, 2)),
                   16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)),
                   16'($urandom_range(0, 1)));
      end else begin
        // A word with its true length at the start, mostly; later lengths are ignored.
        len = $urandom_range(1, 8);
        for (i = 0; i < len; i++) begin
          code = alphabet[$urandom_range(0, 16)];
          type_char(code, (i == 0 && $urandom_range(0, 5) != 0) ? 8'(len) : 8'($urandom));
        end
        pick = $urandom_range(0, 19);
        if (pick < 14) type_char(CODE_SPACE, 8'($urandom));
        else if (pick < 17) type_char(CODE_NEWLINE, 8'($urandom));
      end
    end
  endtask

  initial begin
    int row;
    int phase;
    int rows_pick;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_LOAD;
    in_ch.row_index  = '0;
    in_ch.row_x      = '0;
    in_ch.row_y      = '0;
    in_ch.row_third  = '0;
    in_ch.char_code  = '0;
    in_ch.word_chars = '0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_CHAR_ADVANCE;
    cfg_data         = '0;
    run_done         = 1'b0;
    rst_n            = 1'b0;

    alphabet    = '{"H", "e", "l", "o", "w", "M", "z", "q", "k", "r", "d", "x", "y",
                    8'hFF, 8'h00, 8'hA5, "#"};
    glyph_heads = '{0, 10, 20, 30, 70, 140, 220, 500};

    // Random background rows, then the glyphs laid over them. The table is
    // loaded in full so that no scan ever touches an unwritten row.
    for (row = 0; row < TABLE_ROWS; row++) begin
      image_x[row]   = 16'($urandom);
      image_y[row]   = 16'($urandom);
      image_pen[row] = 16'($urandom);
    end
    place_glyph(0, "H", 3);
    place_glyph(10, "e", 5);
    place_glyph(20, "l", 2);
    place_glyph(30, "o", 4);
    place_glyph(40, "H", 7);
    place_glyph(50, 8'hFF, 1);
    place_glyph(60, 8'h00, 2);
    place_glyph(70, "w", 64);
    place_glyph(140, "M", 100);
    place_glyph(210, "z", 0);
    place_glyph(215, "q", -3);
    place_glyph(216, "k", -32768);
    place_glyph(220, "r", 6);
    place_glyph(300, 8'hA5, 2);
    place_glyph(500, "d", 3);
    place_glyph(1010, "x", 40);
    place_glyph(TABLE_ROWS - 1, "y", 5);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: nothing is scanned, but wrapping still moves the line.
    type_char("a", 8'd21);
    type_char(CODE_SPACE, 8'd0);
    type_char(CODE_NEWLINE, 8'd0);

    for (row = 0; row < TABLE_ROWS; row++)
      load_row(10'(row), image_x[row], image_y[row], image_pen[row]);

    wait_for_strokes();
    program_regs(5, TABLE_ROWS);
    type_char("H", 8'd5);
    type_char("e", 8'd0);
    type_char("l", 8'd0);
    type_char("o", 8'd0);
    type_char(CODE_SPACE, 8'd0);
    type_char("w", 8'd15);       // word length makes the width need exactly 100 mm, no wrap
    type_char("M", 8'd0);
    type_char(CODE_SPACE, 8'd0);
    type_char("x", 8'd13);       // wraps, and runs off the end of the table
    type_char("y", 8'd0);
    type_char("z", 8'd0);
    type_char("q", 8'd0);
    type_char("k", 8'd0);
    type_char("#", 8'd0);
    type_char(8'hFF, 8'd0);
    type_char(8'h00, 8'd0);
    type_char(8'hA5, 8'd0);
    type_char("d", 8'd0);
    type_char(CODE_SPACE, 8'd0);
    type_char("r", 8'd255);

    wait_for_strokes();
    program_regs(0, 1);
    type_char(CODE_SPACE, 8'd0);
    type_char("H", 8'd255);
    type_char("e", 8'd0);

    wait_for_strokes();
    program_regs(100, TABLE_ROWS);
    type_char(CODE_NEWLINE, 8'd0);
    type_char("o", 8'd1);
    type_char(CODE_SPACE, 8'd0);
    type_char("l", 8'd1);

    for (phase = 0; phase < 4; phase++) begin
      wait_for_strokes();
      if (phase == 3) idle_bursts <= 1'b0;
      rows_pick = $urandom_range(0, 3);
      program_regs(($urandom_range(0, 3) == 0) ? $urandom_range(1, 100) : $urandom_range(1, 8),
                   (rows_pick == 1) ? $urandom_range(0, TABLE_ROWS) :
                   (rows_pick == 2) ? 512 : TABLE_ROWS);
      if (phase == 1) begin
        // Keep offering long glyphs while the receiver holds off.
        hold_request <= 1'b1;
        for (row = 0; row < 6; row++) type_char((row % 2 == 0) ? "w" : "M", 8'd2);
      end
      random_text(40);
    end

    wait_for_strokes();
    run_done <= 1'b1;
    repeat (3) @(posedge clk);
    $display("Typed %0d characters and loaded %0d font rows under %0d register settings.",
             text_items, load_items, settings_used);
    $display("Checked %0d strokes, with word wrap, shadowed, truncated and missing glyphs.",
             strokes_checked);
    if (mismatch_total == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/ttsl_pkg.sv
rtl/ttsl_in_if.sv
rtl/ttsl_out_if.sv
rtl/text_to_stroke_layout.sv
sim/text_to_stroke_layout_checker.sv
sim/text_to_stroke_layout_tb.sv
